/* design/fcr_pkg.sv */
// Package for the feedback comb echo block: default sizes, register map,
// gain limits and the configuration struct. No dependencies.
package fcr_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int MaxChannelsDef = 8;
  localparam int MaxDelayDef    = 16384;
  localparam int SampleWidthDef = 24;

  // Configuration register widths.
  localparam int CfgChanW  = 4;
  localparam int CfgDelayW = 15;
  localparam int CfgFbW    = 16;
  localparam int CfgMixW   = 17;
  localparam int CfgDataW  = 17;
  localparam int CfgIdxW   = 3;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] RegEnable   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegChannels = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDelay    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFeedback = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWetMix   = 3'd4;

  // Gain limits (unsigned Q0.16, mix Q1.16) and rounding constants.
  localparam logic [CfgFbW-1:0]  FeedbackMax = 16'd62259;
  localparam logic [CfgMixW-1:0] MixOne      = 17'd65536;
  localparam int                 GainShift   = 16;
  localparam int                 RoundHalf   = 32768;

  // Configuration register set.
  typedef struct packed {
    logic                 enable;
    logic [CfgChanW-1:0]  channel_count;
    logic [CfgDelayW-1:0] delay_length;
    logic [CfgFbW-1:0]    feedback_gain;
    logic [CfgMixW-1:0]   wet_mix;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    enable:        1'b0,
    channel_count: 4'd1,
    delay_length:  15'd1,
    feedback_gain: 16'd0,
    wet_mix:       17'd0
  };

endpackage

/* design/fcr_ram.sv */
// Single-port-write, single-port-read delay memory with a registered read.
// No dependencies.
module fcr_ram #(
  parameter int Depth = 131072,
  parameter int AddrW = 17,
  parameter int DataW = 24
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered; a same-cycle write is not seen.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/fcr_seq.sv */
// Address sequencer: channel position, ring index and frame count, and the
// store address of each accepted sample. Depends on fcr_pkg.
module fcr_seq #(
  parameter int MaxChannels = fcr_pkg::MaxChannelsDef,
  parameter int MaxDelay    = fcr_pkg::MaxDelayDef,
  parameter int AddrW       = $clog2(MaxChannels * MaxDelay)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fcr_pkg::cfg_t     cfg_i,
  input  logic              start_i,
  input  logic              advance_i,
  output logic [AddrW-1:0]  addr_o,
  output logic              use_delayed_o
);

  localparam int ChPosW = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
  localparam int ChCntW = $clog2(MaxChannels + 1);
  localparam int RingW  = $clog2(MaxDelay);
  localparam int FrameW = $clog2(MaxDelay + 1);

  logic [ChPosW-1:0] ch_pos_q, ch_pos_d, ch_pos_cur;
  logic [RingW-1:0]  ring_q, ring_d, ring_cur;
  logic [FrameW-1:0] frames_q, frames_d, frames_cur;
  logic [ChCntW-1:0] chans_eff;
  logic [FrameW-1:0] delay_eff;
  logic [ChPosW:0]   ch_pos_inc;
  logic [RingW:0]    ring_inc;
  logic              frame_done;
  logic              ring_wrap;

  // Clamp the channel count and the delay into their legal ranges.
  always_comb begin
    if (cfg_i.channel_count == '0) begin
      chans_eff = ChCntW'(1);
    end else if (32'(cfg_i.channel_count) > 32'(MaxChannels)) begin
      chans_eff = ChCntW'(MaxChannels);
    end else begin
      chans_eff = ChCntW'(cfg_i.channel_count);
    end
    if (cfg_i.delay_length == '0) begin
      delay_eff = FrameW'(1);
    end else if (32'(cfg_i.delay_length) > 32'(MaxDelay)) begin
      delay_eff = FrameW'(MaxDelay);
    end else begin
      delay_eff = FrameW'(cfg_i.delay_length);
    end
  end

  // A start of block clears the position before this sample uses it.
  assign ch_pos_cur = start_i ? '0 : ch_pos_q;
  assign ring_cur   = start_i ? '0 : ring_q;
  assign frames_cur = start_i ? '0 : frames_q;

  assign addr_o = AddrW'(ch_pos_cur) * AddrW'(MaxDelay) + AddrW'(ring_cur);
  assign use_delayed_o = 32'(frames_cur) >= 32'(delay_eff);

  // Advance the channel, and the ring slot once per frame.
  assign ch_pos_inc = (ChPosW + 1)'(ch_pos_cur) + 1'b1;
  assign ring_inc   = (RingW + 1)'(ring_cur) + 1'b1;
  assign frame_done = 32'(ch_pos_inc) >= 32'(chans_eff);
  assign ring_wrap  = (32'(ring_inc) >= 32'(delay_eff)) || (32'(ring_inc) >= 32'(MaxDelay));

  always_comb begin
    ch_pos_d = ch_pos_q;
    ring_d   = ring_q;
    frames_d = frames_q;
    if (advance_i) begin
      ring_d   = ring_cur;
      frames_d = frames_cur;
      if (frame_done) begin
        ch_pos_d = '0;
        ring_d   = ring_wrap ? '0 : RingW'(ring_inc);
        if (32'(frames_cur) < 32'(MaxDelay)) begin
          frames_d = frames_cur + 1'b1;
        end
      end else begin
        ch_pos_d = ChPosW'(ch_pos_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_pos_q <= '0;
      ring_q   <= '0;
      frames_q <= '0;
    end else begin
      ch_pos_q <= ch_pos_d;
      ring_q   <= ring_d;
      frames_q <= frames_d;
    end
  end

endmodule

/* design/fcr_mac.sv */
// Gain datapath: products in the first stage, then sums with rounding and
// saturation for the output and for the value written back. Depends on fcr_pkg.
module fcr_mac #(
  parameter int SampleWidth = fcr_pkg::SampleWidthDef
) (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  fcr_pkg::cfg_t                 cfg_i,
  input  logic signed [SampleWidth-1:0] dry_i,
  input  logic signed [SampleWidth-1:0] delayed_i,
  output logic signed [SampleWidth-1:0] dry_o,
  output logic signed [SampleWidth-1:0] out_o,
  output logic signed [SampleWidth-1:0] store_o
);

  localparam int ProdW = SampleWidth + 18;
  localparam int AccW  = SampleWidth + 19;
  localparam logic signed [AccW-1:0] SatHi =
    {{(AccW - SampleWidth + 1){1'b0}}, {(SampleWidth - 1){1'b1}}};
  localparam logic signed [AccW-1:0] SatLo = ~SatHi;

  logic [fcr_pkg::CfgMixW-1:0] mix_eff, mix_inv;
  logic [fcr_pkg::CfgFbW-1:0]  fb_eff;
  logic signed [ProdW-1:0]     prod_dry_d, prod_wet_d, prod_fb_d;
  logic signed [ProdW-1:0]     prod_dry_q, prod_wet_q, prod_fb_q;
  logic signed [SampleWidth-1:0] dry_q;
  logic signed [AccW-1:0]      acc_out, acc_store;

  // Round half up, then clamp to the sample range.
  function automatic logic signed [SampleWidth-1:0] round_sat(
    input logic signed [AccW-1:0] acc
  );
    logic signed [AccW-1:0] shifted;
    shifted = acc >>> fcr_pkg::GainShift;
    if (shifted > SatHi) begin
      return SatHi[SampleWidth-1:0];
    end else if (shifted < SatLo) begin
      return SatLo[SampleWidth-1:0];
    end
    return shifted[SampleWidth-1:0];
  endfunction

  // Clamp the gains.
  assign mix_eff = (cfg_i.wet_mix > fcr_pkg::MixOne) ? fcr_pkg::MixOne : cfg_i.wet_mix;
  assign mix_inv = fcr_pkg::MixOne - mix_eff;
  assign fb_eff  = (cfg_i.feedback_gain > fcr_pkg::FeedbackMax) ?
                   fcr_pkg::FeedbackMax : cfg_i.feedback_gain;

  // Stage one: the three products.
  assign prod_dry_d = ProdW'(dry_i) * ProdW'($signed({1'b0, mix_inv}));
  assign prod_wet_d = ProdW'(delayed_i) * ProdW'($signed({1'b0, mix_eff}));
  assign prod_fb_d  = ProdW'(delayed_i) * ProdW'($signed({2'b00, fb_eff}));

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_dry_q <= prod_dry_d;
      prod_wet_q <= prod_wet_d;
      prod_fb_q  <= prod_fb_d;
      dry_q      <= dry_i;
    end
  end

  // Stage two: sums with rounding bias.
  assign acc_out   = AccW'(prod_dry_q) + AccW'(prod_wet_q) + AccW'(fcr_pkg::RoundHalf);
  assign acc_store = (AccW'(dry_q) <<< fcr_pkg::GainShift) + AccW'(prod_fb_q) +
                     AccW'(fcr_pkg::RoundHalf);

  assign out_o   = round_sat(acc_out);
  assign store_o = round_sat(acc_store);
  assign dry_o   = dry_q;

endmodule

/* design/feedback_comb_reverb_top.sv */
// Top level of the feedback comb echo block: configuration registers, stage
// control, address interlock and forwarding. Depends on fcr_pkg, fcr_ram,
// fcr_seq and fcr_mac.
//
//   Channel  | Handshake                  | Payload
//   ---------+----------------------------+---------------------------------
//   input    | in_valid_i / in_ready_o    | sample_in_i, start_of_block_i
//   output   | out_valid_o / out_ready_i  | sample_out_o
//   config   | cfg_we_i (no wait)         | cfg_index_i, cfg_wdata_i
//
// One sample per clock is taken in steady state unless the output stalls or
// the interlock holds it; each result passes stage one, stage two and the
// output register. When channel_count and delay_length are both 1, each
// sample reads the slot the previous one writes and the address interlock
// holds each transfer until that write-back is leaving stage two.
// Reset clears the control state only; the delay memory is not cleared, the
// frame count masks its unwritten history.
// A stalled output holds in the output register while the two pipeline
// stages keep taking samples until they are full.
module feedback_comb_reverb_top #(
  parameter int MAX_CHANNELS = fcr_pkg::MaxChannelsDef,
  parameter int MAX_DELAY    = fcr_pkg::MaxDelayDef,
  parameter int SAMPLE_WIDTH = fcr_pkg::SampleWidthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fcr_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [fcr_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]  sample_in_i,
  input  logic                            start_of_block_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]  sample_out_o
);

  localparam int Depth = MAX_CHANNELS * MAX_DELAY;
  localparam int AddrW = $clog2(Depth);

  fcr_pkg::cfg_t cfg_q, cfg_d;

  logic [AddrW-1:0] in_addr;
  logic             in_use;
  logic             in_xfer;
  logic             hazard;

  logic                           s1_valid_q, s1_wr_q, s1_use_q, s1_fwd_q;
  logic [AddrW-1:0]               s1_addr_q;
  logic signed [SAMPLE_WIDTH-1:0] s1_dry_q, s1_fwd_data_q;
  logic                           s2_valid_q, s2_wr_q;
  logic [AddrW-1:0]               s2_addr_q;
  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_data_q;

  logic out_load, s2_move, s2_free, s1_move, s1_free;
  logic store_we;
  logic [SAMPLE_WIDTH-1:0]        rdata;
  logic signed [SAMPLE_WIDTH-1:0] delayed;
  logic signed [SAMPLE_WIDTH-1:0] s2_dry, s2_out, s2_store;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        fcr_pkg::RegEnable:   cfg_d.enable        = cfg_wdata_i[0];
        fcr_pkg::RegChannels: cfg_d.channel_count = cfg_wdata_i[fcr_pkg::CfgChanW-1:0];
        fcr_pkg::RegDelay:    cfg_d.delay_length  = cfg_wdata_i[fcr_pkg::CfgDelayW-1:0];
        fcr_pkg::RegFeedback: cfg_d.feedback_gain = cfg_wdata_i[fcr_pkg::CfgFbW-1:0];
        fcr_pkg::RegWetMix:   cfg_d.wet_mix       = cfg_wdata_i[fcr_pkg::CfgMixW-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= fcr_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Address sequencer.
  fcr_seq #(
    .MaxChannels (MAX_CHANNELS),
    .MaxDelay    (MAX_DELAY),
    .AddrW       (AddrW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .start_i       (start_of_block_i),
    .advance_i     (in_xfer && cfg_q.enable),
    .addr_o        (in_addr),
    .use_delayed_o (in_use)
  );

  // Stage flow: each stage moves when the one after it frees up.
  assign out_load = !out_valid_q || out_ready_i;
  assign s2_move  = s2_valid_q && out_load;
  assign s2_free  = !s2_valid_q || s2_move;
  assign s1_move  = s1_valid_q && s2_free;
  assign s1_free  = !s1_valid_q || s1_move;

  // Interlock: a slot still waiting for its write-back in stage one, or in a
  // stalled stage two, cannot be read yet.
  assign hazard = cfg_q.enable && (
                  (s1_valid_q && s1_wr_q && (s1_addr_q == in_addr)) ||
                  (s2_valid_q && s2_wr_q && !s2_move && (s2_addr_q == in_addr)));

  assign in_ready_o = s1_free && !hazard;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign store_we   = s2_move && s2_wr_q;

  // Delay memory.
  fcr_ram #(
    .Depth (Depth),
    .AddrW (AddrW),
    .DataW (SAMPLE_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (s2_addr_q),
    .wdata_i (s2_store),
    .re_i    (in_xfer),
    .raddr_i (in_addr),
    .rdata_o (rdata)
  );

  // Stage one: capture the sample, and the write-back landing on its slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_wr_q       <= cfg_q.enable;
      s1_use_q      <= cfg_q.enable && in_use;
      s1_addr_q     <= in_addr;
      s1_dry_q      <= sample_in_i;
      s1_fwd_q      <= store_we && (s2_addr_q == in_addr);
      s1_fwd_data_q <= s2_store;
    end
  end

  always_comb begin
    if (!s1_use_q) begin
      delayed = '0;
    end else if (s1_fwd_q) begin
      delayed = s1_fwd_data_q;
    end else begin
      delayed = $signed(rdata);
    end
  end

  // Products and sums.
  fcr_mac #(
    .SampleWidth (SAMPLE_WIDTH)
  ) u_mac (
    .clk_i     (clk_i),
    .load_i    (s1_move),
    .cfg_i     (cfg_q),
    .dry_i     (s1_dry_q),
    .delayed_i (delayed),
    .dry_o     (s2_dry),
    .out_o     (s2_out),
    .store_o   (s2_store)
  );

  // Stage two control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= s1_move;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_wr_q   <= s1_wr_q;
      s2_addr_q <= s1_addr_q;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      out_data_q <= s2_wr_q ? s2_out : s2_dry;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_data_q;

endmodule

/* design/fcr_checker.sv */
// Port-level checker for the feedback comb echo block, bound to the top
// level. Depends on fcr_pkg and feedback_comb_reverb_top.
module fcr_checker #(
  parameter int SAMPLE_WIDTH = fcr_pkg::SampleWidthDef
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic signed [SAMPLE_WIDTH-1:0]  sample_in_i,
  input logic                            start_of_block_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic signed [SAMPLE_WIDTH-1:0]  sample_out_o
);

  logic [2:0] inflight_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // Samples taken in and not yet handed out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 3'(in_xfer) - 3'(out_xfer);
    end
  end

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_out_o))
    else $error("stalled result changed");

  // A waiting input transfer holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(sample_in_i) &&
    $stable(start_of_block_i))
    else $error("waiting sample changed");

  // No result without a sample in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != 3'd0)
    else $error("result without a pending sample");

  // The block holds at most two stages plus the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd3)
    else $error("more samples in flight than stages");

  // An empty block always takes a sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q == 3'd0 |-> in_ready_o)
    else $error("empty block refused a sample");

endmodule

bind feedback_comb_reverb_top fcr_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_fcr_checker (.*);
